>>> rtl/core/tvp_pkg.sv
// Shared types and constants for the triangle vertex projection block.
`timescale 1ns / 1ps
`default_nettype none
package tvp_pkg;

  // Fixed field widths
  localparam int IN_W     = 32;
  localparam int ROW_W    = 64;
  localparam int CTR_W    = 15;
  localparam int SCR_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Clip-space accumulator saturates to a signed 47-bit range
  localparam int ACC_W    = 47;
  localparam int S_W      = ACC_W + 1;
  localparam int HALF_W   = S_W / 2;
  localparam int MAG_W    = ACC_W + SCR_W;
  localparam int NUM_W    = MAG_W + 1;

  // Pipeline depths of the lane parts
  localparam int DOT_LAT  = 2;
  localparam int MAP_LAT  = 3 + SCR_W;
  localparam int LANE_LAT = DOT_LAT + MAP_LAT;
  localparam int NUM_LANES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_ROW3 = 3'd3,
    REG_CX   = 3'd4,
    REG_CY   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EDGE_01 = 2'd0,
    EDGE_12 = 2'd1,
    EDGE_20 = 2'd2
  } edge_t;

  // Projected screen point of one vertex
  typedef struct packed {
    logic [SCR_W-1:0] sx;
    logic [SCR_W-1:0] sy;
    logic             zw;
  } scr_pt_t;

endpackage
`default_nettype wire

>>> rtl/core/triangle_vertex_projection.sv
// Top level: config registers, three vertex lanes and the edge merge stage.
// An accepted triangle passes the row dot products, then screen mapping and the divider,
//   then the merge register, before its first edge beat.
// The merge stage issues one edge beat per cycle while out_ready is high and stalls the
//   lanes until its last edge is taken; lanes take a whole triangle per cycle when not stalled.
// Reset: synchronous active-low rst_n clears valid state and the config registers.
`timescale 1ns / 1ps
`default_nettype none
module triangle_vertex_projection #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v0_x,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v0_y,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v0_z,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v1_x,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v1_y,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v1_z,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v2_x,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v2_y,
  input  logic signed [tvp_pkg::IN_W-1:0]   in_v2_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tvp_pkg::SCR_W-1:0]         out_start_x,
  output logic [tvp_pkg::SCR_W-1:0]         out_start_y,
  output logic [tvp_pkg::SCR_W-1:0]         out_end_x,
  output logic [tvp_pkg::SCR_W-1:0]         out_end_y,
  output logic                              out_degenerate,
  output logic                              out_last_edge,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tvp_pkg::ROW_W-1:0]         cfg_data
);
  import tvp_pkg::*;

  logic [ROW_W-1:0]   row0_r, row1_r, row2_r, row3_r;
  logic [CTR_W-1:0]   cx_r, cy_r;
  logic               en;
  logic [LANE_LAT-1:0] vld_r;
  scr_pt_t            lane_pt [NUM_LANES];
  scr_pt_t            pt_r    [NUM_LANES];
  logic               mrg_vld_r, mrg_vld_nxt;
  edge_t              edge_r, edge_nxt;
  scr_pt_t            pa, pb;
  logic [IN_W-1:0]    vin [NUM_LANES][3];

  // Config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= '0;
      row1_r <= '0;
      row2_r <= '0;
      row3_r <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ROW0: row0_r <= cfg_data;
        REG_ROW1: row1_r <= cfg_data;
        REG_ROW2: row2_r <= cfg_data;
        REG_ROW3: row3_r <= cfg_data;
        REG_CX:   cx_r   <= cfg_data[CTR_W-1:0];
        REG_CY:   cy_r   <= cfg_data[CTR_W-1:0];
        default:  ;
      endcase
    end
  end

  // Advance the lanes whenever the merge stage is free or finishing
  assign en       = !mrg_vld_r || (out_ready && edge_r == EDGE_20);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LANE_LAT-2:0], in_valid};
    end
  end

  // Vertex lanes
  always_comb begin
    vin[0][0] = in_v0_x; vin[0][1] = in_v0_y; vin[0][2] = in_v0_z;
    vin[1][0] = in_v1_x; vin[1][1] = in_v1_y; vin[1][2] = in_v1_z;
    vin[2][0] = in_v2_x; vin[2][1] = in_v2_y; vin[2][2] = in_v2_z;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    tvp_vertex_lane #(.CW(COORD_WIDTH), .CFW(COEF_WIDTH)) u_lane (
      .clk(clk), .en(en),
      .row0(row0_r), .row1(row1_r), .row3(row3_r),
      .cx(cx_r), .cy(cy_r),
      .vx(vin[l][0]), .vy(vin[l][1]), .vz(vin[l][2]),
      .pt(lane_pt[l])
    );
  end

  // Merge stage: hold three points, step through the edges
  always_comb begin
    mrg_vld_nxt = mrg_vld_r;
    edge_nxt    = edge_r;
    if (en) begin
      mrg_vld_nxt = vld_r[LANE_LAT-1];
      edge_nxt    = EDGE_01;
    end else if (out_ready) begin
      unique case (edge_r)
        EDGE_01: edge_nxt = EDGE_12;
        EDGE_12: edge_nxt = EDGE_20;
        default: edge_nxt = EDGE_20;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrg_vld_r <= 1'b0;
      edge_r    <= EDGE_01;
    end else begin
      mrg_vld_r <= mrg_vld_nxt;
      edge_r    <= edge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        pt_r[l] <= lane_pt[l];
      end
    end
  end

  // Edge output selection
  always_comb begin
    unique case (edge_r)
      EDGE_01: begin pa = pt_r[0]; pb = pt_r[1]; end
      EDGE_12: begin pa = pt_r[1]; pb = pt_r[2]; end
      default: begin pa = pt_r[2]; pb = pt_r[0]; end
    endcase
  end

  assign out_valid      = mrg_vld_r;
  assign out_start_x    = pa.sx;
  assign out_start_y    = pa.sy;
  assign out_end_x      = pb.sx;
  assign out_end_y      = pb.sy;
  assign out_degenerate = pa.zw | pb.zw;
  assign out_last_edge  = (edge_r == EDGE_20);

`ifndef SYNTHESIS
  a_edge_needs_tri: assert property (@(posedge clk) disable iff (!rst_n)
    edge_r != EDGE_01 |-> mrg_vld_r)
    else $error("edge counter moved without a held triangle");

  a_edge_holds: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_vld_r && !out_ready |=> $stable(edge_r))
    else $error("edge counter moved while output stalled");

  a_tri_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_edge |=> out_valid)
    else $error("triangle dropped before its last edge");

  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_vld_r && edge_r != EDGE_20 |-> !in_ready)
    else $error("input taken while edges remain");
`endif

endmodule
`default_nettype wire

>>> rtl/core/tvp_row_dot.sv
// One matrix row times a homogeneous vertex, floored products, saturated sum.
`timescale 1ns / 1ps
`default_nettype none
module tvp_row_dot #(
  parameter int CW  = 32,
  parameter int CFW = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tvp_pkg::ROW_W-1:0]         row,
  input  logic signed [CW-1:0]              crd [3],
  output logic signed [tvp_pkg::ACC_W-1:0]  acc
);
  import tvp_pkg::*;

  localparam int FRAC = CFW - 4;
  localparam int PW   = CW + CFW;
  localparam int SW   = (CW + 6 > ACC_W + 1) ? CW + 6 : ACC_W + 1;

  logic signed [CFW-1:0] coef [4];
  logic signed [PW-1:0]  prod_r [3];
  logic signed [CFW-1:0] k_r;
  logic signed [SW-1:0]  sum;
  logic signed [ACC_W-1:0] acc_r;

  // Unpack coefficients
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      coef[c] = signed'(row[16*c +: CFW]);
    end
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= PW'(crd[c]) * PW'(coef[c]);
      end
      k_r <= coef[3];
    end
  end

  // Stage 2: floor-shift, sum with constant term, saturate
  always_comb begin
    sum = SW'(k_r) <<< (16 - FRAC);
    for (int c = 0; c < 3; c++) begin
      sum = sum + SW'(prod_r[c] >>> FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum[SW-1:ACC_W-1] == {(SW-ACC_W+1){1'b0}} ||
          sum[SW-1:ACC_W-1] == {(SW-ACC_W+1){1'b1}}) begin
        acc_r <= sum[ACC_W-1:0];
      end else if (sum[SW-1]) begin
        acc_r <= {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
        acc_r <= {1'b0, {(ACC_W-1){1'b1}}};
      end
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

>>> rtl/core/tvp_screen_map.sv
// Screen mapping center*(W+A)/W with a pipelined restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module tvp_screen_map (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tvp_pkg::CTR_W-1:0]         center,
  input  logic signed [tvp_pkg::ACC_W-1:0]  a,
  input  logic signed [tvp_pkg::ACC_W-1:0]  w,
  input  logic                              zw_in,
  output logic [tvp_pkg::SCR_W-1:0]         q,
  output logic                              zw_out
);
  import tvp_pkg::*;

  logic signed [S_W-1:0]          s;
  logic [CTR_W+HALF_W-1:0]        plo_r;
  logic signed [CTR_W+HALF_W:0]   phi_r;
  logic signed [ACC_W-1:0]        w1_r, w2_r;
  logic                           zw1_r, zw2_r;
  logic signed [NUM_W-1:0]        hi_ext, lo_ext, num, num_r;
  logic [NUM_W-1:0]               nabs;
  logic [ACC_W-1:0]               wabs;
  logic [MAG_W-1:0]               rem_r [SCR_W+1];
  logic [ACC_W-1:0]               d_r   [SCR_W+1];
  logic [SCR_W-1:0]               q_r   [SCR_W+1];
  logic                           f_r   [SCR_W+1];
  logic                           sat_r [SCR_W+1];
  logic                           zw_r  [SCR_W+1];
  logic [MAG_W-1:0]               shd   [SCR_W];
  logic                           ge    [SCR_W];

  assign s = S_W'(w) + S_W'(a);

  // Stage M1: split product of center and W+A
  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= center * s[HALF_W-1:0];
      phi_r <= signed'({1'b0, center}) * signed'(s[S_W-1:HALF_W]);
      w1_r  <= w;
      zw1_r <= zw_in;
    end
  end

  // Stage M2: combine partial products
  always_comb begin
    hi_ext = NUM_W'(phi_r);
    lo_ext = NUM_W'(plo_r);
    num    = (hi_ext <<< HALF_W) + lo_ext;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num;
      w2_r  <= w1_r;
      zw2_r <= zw1_r;
    end
  end

  // Stage M3: magnitudes, sign and overflow check
  assign nabs = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign wabs = w2_r[ACC_W-1] ? ACC_W'(-w2_r) : ACC_W'(w2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= nabs[MAG_W-1:0];
      d_r[0]   <= wabs;
      q_r[0]   <= '0;
      f_r[0]   <= zw2_r | (num_r[NUM_W-1] ^ w2_r[ACC_W-1]);
      sat_r[0] <= (nabs[MAG_W-1:0] >= {wabs, {SCR_W{1'b0}}});
      zw_r[0]  <= zw2_r;
    end
  end

  // Divider: one quotient bit per stage, MSB first
  always_comb begin
    for (int k = 0; k < SCR_W; k++) begin
      shd[k] = MAG_W'(d_r[k]) << (SCR_W - 1 - k);
      ge[k]  = (rem_r[k] >= shd[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SCR_W; k++) begin
        rem_r[k+1] <= ge[k] ? rem_r[k] - shd[k] : rem_r[k];
        q_r[k+1]   <= q_r[k] | (ge[k] ? (SCR_W'(1) << (SCR_W - 1 - k)) : '0);
        d_r[k+1]   <= d_r[k];
        f_r[k+1]   <= f_r[k];
        sat_r[k+1] <= sat_r[k];
        zw_r[k+1]  <= zw_r[k];
      end
    end
  end

  // Clamp: opposite signs or zero W give 0, overflow gives full scale
  assign q = f_r[SCR_W] ? '0 : (sat_r[SCR_W] ? '1 : q_r[SCR_W]);
  assign zw_out = zw_r[SCR_W];

endmodule
`default_nettype wire

>>> rtl/core/tvp_vertex_lane.sv
// One vertex lane: clip-space X, Y, W then screen x and y.
`timescale 1ns / 1ps
`default_nettype none
module tvp_vertex_lane #(
  parameter int CW  = 32,
  parameter int CFW = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tvp_pkg::ROW_W-1:0]    row0,
  input  logic [tvp_pkg::ROW_W-1:0]    row1,
  input  logic [tvp_pkg::ROW_W-1:0]    row3,
  input  logic [tvp_pkg::CTR_W-1:0]    cx,
  input  logic [tvp_pkg::CTR_W-1:0]    cy,
  input  logic [tvp_pkg::IN_W-1:0]     vx,
  input  logic [tvp_pkg::IN_W-1:0]     vy,
  input  logic [tvp_pkg::IN_W-1:0]     vz,
  output tvp_pkg::scr_pt_t             pt
);
  import tvp_pkg::*;

  logic [CW+IN_W-1:0]      ex, ey, ez;
  logic signed [CW-1:0]    crd [3];
  logic signed [ACC_W-1:0] xa, ya, wa;
  logic                    wz;
  logic [SCR_W-1:0]        qx, qy;
  logic                    zw;

  // Take the low CW bits of each coordinate as signed
  always_comb begin
    ex = {{CW{1'b0}}, vx};
    ey = {{CW{1'b0}}, vy};
    ez = {{CW{1'b0}}, vz};
    crd[0] = signed'(ex[CW-1:0]);
    crd[1] = signed'(ey[CW-1:0]);
    crd[2] = signed'(ez[CW-1:0]);
  end

  tvp_row_dot #(.CW(CW), .CFW(CFW)) u_dot_x (
    .clk(clk), .en(en), .row(row0), .crd(crd), .acc(xa)
  );
  tvp_row_dot #(.CW(CW), .CFW(CFW)) u_dot_y (
    .clk(clk), .en(en), .row(row1), .crd(crd), .acc(ya)
  );
  tvp_row_dot #(.CW(CW), .CFW(CFW)) u_dot_w (
    .clk(clk), .en(en), .row(row3), .crd(crd), .acc(wa)
  );

  assign wz = (wa == '0);

  tvp_screen_map u_map_x (
    .clk(clk), .en(en), .center(cx), .a(xa), .w(wa), .zw_in(wz),
    .q(qx), .zw_out(zw)
  );
  tvp_screen_map u_map_y (
    .clk(clk), .en(en), .center(cy), .a(ya), .w(wa), .zw_in(wz),
    .q(qy), .zw_out()
  );

  assign pt.sx = qx;
  assign pt.sy = qy;
  assign pt.zw = zw;

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the triangle vertex projection block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import tvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd7;
  localparam logic signed [IN_W-1:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct packed {
    logic [SCR_W-1:0] start_x;
    logic [SCR_W-1:0] start_y;
    logic [SCR_W-1:0] end_x;
    logic [SCR_W-1:0] end_y;
    logic             degenerate;
    logic             last_edge;
  } edge_beat_t;

  typedef logic signed [IN_W-1:0] vert_coords_t [9];

  // Edge predictor and store of expected edge beats
  class edge_scoreboard;
    logic [ROW_W-1:0] rows [4];
    longint           ctr_x, ctr_y;
    edge_beat_t       pending [$];
    int               errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      ctr_x = 0;
      ctr_y = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
      case (idx)
        REG_ROW0: rows[0] = data;
        REG_ROW1: rows[1] = data;
        REG_ROW2: rows[2] = data;
        REG_ROW3: rows[3] = data;
        REG_CX:   ctr_x = longint'(data[CTR_W-1:0]);
        REG_CY:   ctr_y = longint'(data[CTR_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clip_coord(int r, longint vx, longint vy, longint vz);
      longint v [4];
      longint acc;
      logic signed [15:0] c;
      v[0] = vx; v[1] = vy; v[2] = vz; v[3] = 65536;
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        c = rows[r][16*k +: 16];
        acc += (v[k] * longint'(c)) >>> 12;
      end
      if (acc > (64'sd1 <<< 46) - 1) acc = (64'sd1 <<< 46) - 1;
      if (acc < -(64'sd1 <<< 46)) acc = -(64'sd1 <<< 46);
      return acc;
    endfunction

    function logic [SCR_W-1:0] map_axis(longint ctr, longint a, longint w);
      longint q;
      q = (ctr * (w + a)) / w;
      if (q < 0) return '0;
      if (q > 65535) return '1;
      return q[SCR_W-1:0];
    endfunction

    function scr_pt_t project(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                              logic signed [IN_W-1:0] z);
      scr_pt_t p;
      longint cx, cy, cw;
      cx = clip_coord(0, x, y, z);
      cy = clip_coord(1, x, y, z);
      cw = clip_coord(3, x, y, z);
      if (cw == 0) begin
        p = '{sx: '0, sy: '0, zw: 1'b1};
      end else begin
        p.sx = map_axis(ctr_x, cx, cw);
        p.sy = map_axis(ctr_y, cy, cw);
        p.zw = 1'b0;
      end
      return p;
    endfunction

    function void note_triangle(vert_coords_t v);
      scr_pt_t p [3];
      edge_beat_t e;
      for (int i = 0; i < 3; i++) p[i] = project(v[3*i], v[3*i+1], v[3*i+2]);
      for (int i = 0; i < 3; i++) begin
        e.start_x    = p[i].sx;
        e.start_y    = p[i].sy;
        e.end_x      = p[(i+1)%3].sx;
        e.end_y      = p[(i+1)%3].sy;
        e.degenerate = p[i].zw | p[(i+1)%3].zw;
        e.last_edge  = (i == EDGE_20);
        pending.push_back(e);
      end
    endfunction

    task report(string what);
      errors++;
      $display("%0t: mismatch: %s", $realtime, what);
    endtask

    task check(edge_beat_t got);
      edge_beat_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected edge beat %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.start_x != want.start_x)
        report($sformatf("start_x %0d, want %0d", got.start_x, want.start_x));
      if (got.start_y != want.start_y)
        report($sformatf("start_y %0d, want %0d", got.start_y, want.start_y));
      if (got.end_x != want.end_x)
        report($sformatf("end_x %0d, want %0d", got.end_x, want.end_x));
      if (got.end_y != want.end_y)
        report($sformatf("end_y %0d, want %0d", got.end_y, want.end_y));
      if (got.degenerate != want.degenerate)
        report($sformatf("degenerate %0b, want %0b", got.degenerate, want.degenerate));
      if (got.last_edge != want.last_edge)
        report($sformatf("last_edge %0b, want %0b", got.last_edge, want.last_edge));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] in_v0_x = '0, in_v0_y = '0, in_v0_z = '0;
  logic signed [IN_W-1:0] in_v1_x = '0, in_v1_y = '0, in_v1_z = '0;
  logic signed [IN_W-1:0] in_v2_x = '0, in_v2_y = '0, in_v2_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SCR_W-1:0] out_start_x, out_start_y, out_end_x, out_end_y;
  logic out_degenerate, out_last_edge;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;

  edge_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  triangle_vertex_projection u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_v0_x(in_v0_x), .in_v0_y(in_v0_y), .in_v0_z(in_v0_z),
    .in_v1_x(in_v1_x), .in_v1_y(in_v1_y), .in_v1_z(in_v1_z),
    .in_v2_x(in_v2_x), .in_v2_y(in_v2_y), .in_v2_z(in_v2_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_start_x(out_start_x), .out_start_y(out_start_y),
    .out_end_x(out_end_x), .out_end_y(out_end_y),
    .out_degenerate(out_degenerate), .out_last_edge(out_last_edge),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern: modes of no stall, light and heavy back-pressure
  always @(posedge clk) begin : stall_gen
    int mode;
    mode = int'(($time / 2000) % 3);
    case (mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // Check each accepted edge beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check('{out_start_x, out_start_y, out_end_x, out_end_y,
                 out_degenerate, out_last_edge});
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** triangle_vertex_projection: FAILED **");
      $finish;
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected beat, then let the pipeline settle
  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1, logic [ROW_W-1:0] r2,
                  logic [ROW_W-1:0] r3, logic [CTR_W-1:0] cx, logic [CTR_W-1:0] cy);
    drain();
    write_reg(REG_ROW0, r0);
    write_reg(REG_ROW1, r1);
    write_reg(REG_ROW2, r2);
    write_reg(REG_ROW3, r3);
    write_reg(REG_CX, ROW_W'(cx));
    write_reg(REG_CY, ROW_W'(cy));
  endtask

  // Present one triangle, hold until accepted, then either idle or stay valid
  task send_triangle(vert_coords_t v, bit last);
    in_valid <= 1'b1;
    in_v0_x <= v[0]; in_v0_y <= v[1]; in_v0_z <= v[2];
    in_v1_x <= v[3]; in_v1_y <= v[4]; in_v1_z <= v[5];
    in_v2_x <= v[6]; in_v2_y <= v[7]; in_v2_z <= v[8];
    do @(posedge clk); while (!in_ready);
    sb.note_triangle(v);
    if (burst_left > 0) burst_left--;
    if (last || burst_left == 0) begin
      in_valid <= 1'b0;
      if (!last) repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  function vert_coords_t fill(logic signed [IN_W-1:0] a);
    vert_coords_t v;
    foreach (v[i]) v[i] = a;
    return v;
  endfunction

  // Random triangle: mostly small coordinates in front of the camera, some raw bits
  function vert_coords_t rand_triangle();
    vert_coords_t v;
    int kind;
    kind = $urandom_range(0, 9);
    foreach (v[i]) begin
      if (kind < 3) v[i] = $urandom;
      else v[i] = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      if (kind >= 3 && (i % 3) == 2) v[i] = $urandom_range(0, 32'h000A_0000);
      if (kind == 9 && (i % 3) == 2 && $urandom_range(0, 2) == 0) v[i] = '0;
    end
    return v;
  endfunction

  initial begin : stimulus
    vert_coords_t v;
    logic [ROW_W-1:0] rr [4];
    int phase_items;
    // Perspective setup: X = x, Y = y, W = z
    localparam logic [ROW_W-1:0] ROW_X = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_W_Z = 64'h0000_1000_0000_0000;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 12);
    @(posedge clk);

    // Spare register index is ignored
    write_reg(IDX_SPARE, '1);
    set_matrix(ROW_X, ROW_Y, 64'h1234_5678_9ABC_DEF0, ROW_W_Z, 15'd320, 15'd240);

    // Directed: on screen, zero w, off screen, extreme fields
    v = '{ONE_Q16, ONE_Q16, ONE_Q16*2, -ONE_Q16, 0, ONE_Q16*4,
          ONE_Q16/2, -ONE_Q16, ONE_Q16};
    send_triangle(v, 0);
    v = '{ONE_Q16, ONE_Q16, 0, 0, 0, ONE_Q16, ONE_Q16, 0, ONE_Q16};
    send_triangle(v, 0);
    v = '{ONE_Q16*100, -ONE_Q16*100, ONE_Q16, 0, 0, -ONE_Q16,
          -ONE_Q16*7, ONE_Q16*9, ONE_Q16/16};
    send_triangle(v, 0);
    send_triangle(fill(32'sh7FFF_FFFF), 0);
    send_triangle(fill(32'sh8000_0000), 0);
    send_triangle(fill('0), 0);
    send_triangle(fill(-32'sd1), 0);
    v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 0, 1,
          32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1};
    send_triangle(v, 1);

    // Extreme coefficients and centres
    set_matrix({4{16'h7FFF}}, {4{16'h8000}}, '0, {4{16'h8000}}, 15'h7FFF, 15'h7FFF);
    send_triangle(fill(32'sh7FFF_FFFF), 0);
    send_triangle(fill(32'sh8000_0000), 0);
    send_triangle(v, 0);
    send_triangle(fill(ONE_Q16), 1);
    set_matrix('1, '1, '1, {16'h1000, 48'h0}, 15'd0, 15'd0);
    send_triangle(v, 0);
    send_triangle(fill(ONE_Q16*3), 1);

    // Random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        set_matrix(ROW_X, ROW_Y, '0, ROW_W_Z, 15'd320, 15'd240);
      end else begin
        foreach (rr[i]) rr[i] = {$urandom, $urandom};
        // Keep a usable w row most of the time
        if (ph != 4) rr[3][47:32] = 16'($urandom_range(16'h0400, 16'h2000));
        set_matrix(rr[0], rr[1], rr[2], rr[3], 15'($urandom), 15'($urandom));
      end
      phase_items = 42;
      for (int n = 0; n < phase_items; n++) begin
        send_triangle(rand_triangle(), n == phase_items - 1);
        // Hold off once per phase until the pipeline is empty
        if (n == phase_items / 2) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** triangle_vertex_projection: PASSED **");
    end else begin
      $display("** triangle_vertex_projection: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/core/tvp_pkg.sv
rtl/core/tvp_row_dot.sv
rtl/core/tvp_screen_map.sv
rtl/core/tvp_vertex_lane.sv
rtl/core/triangle_vertex_projection.sv
tb/tb.sv
